FILE: rtl/dlpc_pkg.sv
// ============================================================================
// DAG longest path counter - shared package
// Item kinds, field widths and the sequencer state type shared by the core
// and its vertex table.
// ============================================================================
package dlpc_pkg;

    // Widths of the item and result fields.
    localparam int KIND_W      = 2;
    localparam int VID_W       = 6;
    localparam int LEN_W       = 6;
    localparam int OUT_COUNT_W = 32;
    localparam int MASK_W      = 64;

    // A length never grows past this value.
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_EDGE    = 2'd0,
        KIND_QUERY   = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NOP     = 2'd3
    } kind_t;

    // Sequencer states of the core.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EDGE,
        ST_SCAN,
        ST_DRAIN,
        ST_QDONE,
        ST_MISC
    } state_t;

    // Control from the sequencer to the vertex table.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } table_ctrl_t;

endpackage

FILE: rtl/dlpc_vertex_table.sv
// ============================================================================
// DAG longest path counter - vertex table
// Synchronous memory of length and path count per vertex, two read ports and
// one write port, with one valid bit per entry so that a restart clears the
// whole table by clearing every valid bit.
// ============================================================================
module dlpc_vertex_table
    import dlpc_pkg::*;
#(
    parameter int VERTICES   = 64,
    parameter int COUNT_BITS = 32,
    parameter int VIDX_W     = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  table_ctrl_t           ctrl,
    input  logic [VIDX_W-1:0]     addr_a,
    input  logic [VIDX_W-1:0]     addr_b,
    input  logic [VIDX_W-1:0]     wr_addr,
    input  logic [LEN_W-1:0]      wr_len,
    input  logic [COUNT_BITS-1:0] wr_cnt,
    output logic [LEN_W-1:0]      rd_a_len,
    output logic [COUNT_BITS-1:0] rd_a_cnt,
    output logic [LEN_W-1:0]      rd_b_len,
    output logic [COUNT_BITS-1:0] rd_b_cnt
);

    localparam int ENTRY_W = LEN_W + COUNT_BITS;

    logic [ENTRY_W-1:0]  vertex_mem [VERTICES];
    logic [ENTRY_W-1:0]  rd_a_data_reg;
    logic [ENTRY_W-1:0]  rd_b_data_reg;
    logic [VERTICES-1:0] vld_reg;
    logic                rd_a_vld_reg;
    logic                rd_b_vld_reg;

    always_ff @(posedge clk) begin
        if (ctrl.wr_en) begin
            vertex_mem[wr_addr] <= {wr_len, wr_cnt};
        end
        if (ctrl.rd_en) begin
            rd_a_data_reg <= vertex_mem[addr_a];
            rd_b_data_reg <= vertex_mem[addr_b];
        end
    end

    // An entry that was never written since restart holds length 0, count 1.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg      <= '0;
            rd_a_vld_reg <= 1'b0;
            rd_b_vld_reg <= 1'b0;
        end
        else begin
            if (ctrl.clr_all) begin
                vld_reg <= '0;
            end
            else if (ctrl.wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en) begin
                rd_a_vld_reg <= vld_reg[addr_a];
                rd_b_vld_reg <= vld_reg[addr_b];
            end
        end
    end

    assign rd_a_len = rd_a_vld_reg ? rd_a_data_reg[ENTRY_W-1 -: LEN_W] : '0;
    assign rd_a_cnt = rd_a_vld_reg ? rd_a_data_reg[COUNT_BITS-1:0] : COUNT_BITS'(1);
    assign rd_b_len = rd_b_vld_reg ? rd_b_data_reg[ENTRY_W-1 -: LEN_W] : '0;
    assign rd_b_cnt = rd_b_vld_reg ? rd_b_data_reg[COUNT_BITS-1:0] : COUNT_BITS'(1);

endmodule

FILE: rtl/dag_longest_path_counter_core.sv
// ============================================================================
// DAG longest path counter - core
// Edge relaxation, longest path query and restart over a vertex table.
// An edge beat reads the table and then writes the destination back; restart
// and no-op beats commit their result from a single work state; a query scans
// every table entry, then drains and commits. A new item is taken only in the
// idle state, so one item is finished before the next is accepted.
// Reset: all vertices read as length 0 and count 1, the saturation flag is
// clear and every vertex is present. Restart clears the table and the flag.
// ============================================================================
module dag_longest_path_counter_core
    import dlpc_pkg::*;
#(
    parameter int VERTICES   = 64,
    parameter int COUNT_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration: present vertex mask.
    input  logic                   present_mask_we,
    input  logic [MASK_W-1:0]      present_mask_wdata,
    // Item channel.
    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [KIND_W-1:0]      kind,
    input  logic [VID_W-1:0]       src,
    input  logic [VID_W-1:0]       dst,
    // Result channel.
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [LEN_W-1:0]       length,
    output logic [OUT_COUNT_W-1:0] path_count,
    output logic                   saturated
);

    localparam int VIDX_W = $clog2(VERTICES);
    localparam int WIDE_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
    localparam logic [VID_W:0]      VERT_LIM = (VID_W + 1)'(VERTICES);
    localparam logic [VIDX_W-1:0]   LAST_IDX = VIDX_W'(VERTICES - 1);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                  state_reg,     state_next;
    logic [MASK_W-1:0]       mask_reg,      mask_next;
    logic                    sat_flag_reg,  sat_flag_next;
    logic                    restart_reg,   restart_next;
    logic                    edge_ok_reg,   edge_ok_next;
    logic                    dst_ok_reg,    dst_ok_next;
    logic [VIDX_W-1:0]       dst_idx_reg,   dst_idx_next;
    logic [VIDX_W-1:0]       scan_idx_reg,  scan_idx_next;
    logic                    scan_dv_reg,   scan_dv_next;
    logic                    scan_pres_reg, scan_pres_next;
    logic                    any_reg,       any_next;
    logic [LEN_W-1:0]        best_reg,      best_next;
    logic [COUNT_BITS-1:0]   total_reg,     total_next;
    logic                    qovf_reg,      qovf_next;
    logic                    out_valid_reg, out_valid_next;
    logic [LEN_W-1:0]        out_len_reg,   out_len_next;
    logic [OUT_COUNT_W-1:0]  out_cnt_reg,   out_cnt_next;
    logic                    out_sat_reg,   out_sat_next;

    // ------------------------------------------------------------------------
    // Vertex table
    // ------------------------------------------------------------------------
    table_ctrl_t             tctrl;
    logic [VIDX_W-1:0]       addr_a;
    logic [LEN_W-1:0]        wr_len;
    logic [COUNT_BITS-1:0]   wr_cnt;
    logic [LEN_W-1:0]        la;
    logic [LEN_W-1:0]        lb;
    logic [COUNT_BITS-1:0]   ca;
    logic [COUNT_BITS-1:0]   cb;

    dlpc_vertex_table #(
        .VERTICES   (VERTICES),
        .COUNT_BITS (COUNT_BITS),
        .VIDX_W     (VIDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (tctrl),
        .addr_a   (addr_a),
        .addr_b   (dst[VIDX_W-1:0]),
        .wr_addr  (dst_idx_reg),
        .wr_len   (wr_len),
        .wr_cnt   (wr_cnt),
        .rd_a_len (la),
        .rd_a_cnt (ca),
        .rd_b_len (lb),
        .rd_b_cnt (cb)
    );

    // ------------------------------------------------------------------------
    // Handshake and shared arithmetic
    // ------------------------------------------------------------------------
    logic                    item_acc;
    logic                    out_free;
    logic                    src_pres;
    logic                    dst_in;
    logic [VERTICES-1:0]     vmask;

    // The table is busy from acceptance until the result is committed, so a
    // new item is taken only in the idle state. The output register lets a
    // finished result wait while the next item is accepted.
    assign item_stall = (state_reg != ST_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign out_free   = !out_valid_reg || !result_stall;

    assign vmask    = mask_reg[VERTICES-1:0];
    assign dst_in   = ({1'b0, dst} < VERT_LIM);
    assign src_pres = ({1'b0, src} < VERT_LIM) && mask_reg[src];

    assign addr_a = (state_reg == ST_SCAN) ? scan_idx_reg : src[VIDX_W-1:0];

    // Edge relaxation of the destination from the registered table reads.
    logic [COUNT_BITS:0]     edge_sum;
    logic                    edge_sum_ovf;
    logic                    len_ge;
    logic                    len_next_eq;
    logic [LEN_W-1:0]        edge_len;
    logic [COUNT_BITS-1:0]   edge_cnt;
    logic                    edge_we;
    logic                    edge_add_ovf;

    always_comb begin
        edge_sum     = {1'b0, cb} + {1'b0, ca};
        edge_sum_ovf = edge_sum[COUNT_BITS];
        len_ge       = (la >= lb);
        len_next_eq  = (({1'b0, la} + (LEN_W + 1)'(1)) == {1'b0, lb});
        edge_len     = lb;
        edge_cnt     = cb;
        edge_we      = 1'b0;
        edge_add_ovf = 1'b0;
        if (edge_ok_reg) begin
            if (len_ge) begin
                // The source's paths extend to the destination and replace it.
                edge_len = (la == LEN_MAX) ? LEN_MAX : la + LEN_W'(1);
                edge_cnt = ca;
                edge_we  = 1'b1;
            end
            else if (len_next_eq) begin
                // Another set of longest paths reaches the destination.
                edge_cnt     = edge_sum_ovf ? '1 : edge_sum[COUNT_BITS-1:0];
                edge_we      = 1'b1;
                edge_add_ovf = edge_sum_ovf;
            end
        end
    end

    assign wr_len = edge_len;
    assign wr_cnt = edge_cnt;

    // Query accumulation: one table entry arrives per cycle during the scan.
    logic [COUNT_BITS:0]     q_sum;

    assign q_sum = {1'b0, total_reg} + {1'b0, ca};

    // Narrowing of a count to the result width; a wider count saturates.
    logic [COUNT_BITS-1:0]   clamp_in;
    logic [WIDE_W-1:0]       clamp_ext;
    logic                    clamp_wide;
    logic [OUT_COUNT_W-1:0]  clamp_out;

    assign clamp_in   = (state_reg == ST_EDGE) ? edge_cnt : total_reg;
    assign clamp_ext  = WIDE_W'(clamp_in);
    assign clamp_wide = |(clamp_ext >> OUT_COUNT_W);
    assign clamp_out  = clamp_wide ? '1 : clamp_ext[OUT_COUNT_W-1:0];

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '1;
            sat_flag_reg  <= 1'b0;
            restart_reg   <= 1'b0;
            edge_ok_reg   <= 1'b0;
            dst_ok_reg    <= 1'b0;
            dst_idx_reg   <= '0;
            scan_idx_reg  <= '0;
            scan_dv_reg   <= 1'b0;
            scan_pres_reg <= 1'b0;
            any_reg       <= 1'b0;
            best_reg      <= '0;
            total_reg     <= '0;
            qovf_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_len_reg   <= '0;
            out_cnt_reg   <= '0;
            out_sat_reg   <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            sat_flag_reg  <= sat_flag_next;
            restart_reg   <= restart_next;
            edge_ok_reg   <= edge_ok_next;
            dst_ok_reg    <= dst_ok_next;
            dst_idx_reg   <= dst_idx_next;
            scan_idx_reg  <= scan_idx_next;
            scan_dv_reg   <= scan_dv_next;
            scan_pres_reg <= scan_pres_next;
            any_reg       <= any_next;
            best_reg      <= best_next;
            total_reg     <= total_next;
            qovf_reg      <= qovf_next;
            out_valid_reg <= out_valid_next;
            out_len_reg   <= out_len_next;
            out_cnt_reg   <= out_cnt_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        mask_next      = present_mask_we ? present_mask_wdata : mask_reg;
        sat_flag_next  = sat_flag_reg;
        restart_next   = restart_reg;
        edge_ok_next   = edge_ok_reg;
        dst_ok_next    = dst_ok_reg;
        dst_idx_next   = dst_idx_reg;
        scan_idx_next  = scan_idx_reg;
        scan_dv_next   = scan_dv_reg;
        scan_pres_next = scan_pres_reg;
        any_next       = any_reg;
        best_next      = best_reg;
        total_next     = total_reg;
        qovf_next      = qovf_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_len_next   = out_len_reg;
        out_cnt_next   = out_cnt_reg;
        out_sat_next   = out_sat_reg;
        tctrl          = '0;

        // Scan data arriving from the table is folded in during the scan and
        // the drain cycle. A deeper length restarts the running total and its
        // overflow mark, so only sums at the final length count.
        if (scan_dv_reg && scan_pres_reg) begin
            any_next = 1'b1;
            if (!any_reg || (la > best_reg)) begin
                best_next  = la;
                total_next = ca;
                qovf_next  = 1'b0;
            end
            else if (la == best_reg) begin
                total_next = q_sum[COUNT_BITS] ? '1 : q_sum[COUNT_BITS-1:0];
                qovf_next  = qovf_reg || q_sum[COUNT_BITS];
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (item_acc) begin
                    tctrl.rd_en    = 1'b1;
                    edge_ok_next   = src_pres && dst_in && mask_reg[dst];
                    dst_ok_next    = dst_in;
                    dst_idx_next   = dst[VIDX_W-1:0];
                    scan_idx_next  = '0;
                    scan_dv_next   = 1'b0;
                    any_next       = 1'b0;
                    best_next      = '0;
                    total_next     = '0;
                    qovf_next      = 1'b0;
                    restart_next   = 1'b0;
                    unique case (kind_t'(kind))
                        KIND_EDGE: begin
                            state_next = ST_EDGE;
                        end
                        KIND_QUERY: begin
                            state_next = ST_SCAN;
                        end
                        KIND_RESTART: begin
                            restart_next = 1'b1;
                            state_next   = ST_MISC;
                        end
                        KIND_NOP: begin
                            state_next = ST_MISC;
                        end
                        default: begin
                            state_next = ST_MISC;
                        end
                    endcase
                end
            end

            ST_EDGE: begin
                if (out_free) begin
                    tctrl.wr_en    = edge_we;
                    out_valid_next = 1'b1;
                    if (dst_ok_reg) begin
                        out_len_next  = edge_len;
                        out_cnt_next  = clamp_out;
                        sat_flag_next = sat_flag_reg || edge_add_ovf || clamp_wide;
                    end
                    else begin
                        out_len_next  = '0;
                        out_cnt_next  = '0;
                        sat_flag_next = sat_flag_reg;
                    end
                    out_sat_next = sat_flag_next;
                    state_next   = ST_IDLE;
                end
            end

            ST_SCAN: begin
                tctrl.rd_en    = 1'b1;
                scan_dv_next   = 1'b1;
                scan_pres_next = vmask[scan_idx_reg];
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
                else begin
                    scan_idx_next = scan_idx_reg + VIDX_W'(1);
                end
            end

            ST_DRAIN: begin
                scan_dv_next = 1'b0;
                state_next   = ST_QDONE;
            end

            ST_QDONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (any_reg) begin
                        out_len_next  = best_reg;
                        out_cnt_next  = clamp_out;
                        sat_flag_next = sat_flag_reg || qovf_reg || clamp_wide;
                    end
                    else begin
                        out_len_next = '0;
                        out_cnt_next = '0;
                    end
                    out_sat_next = sat_flag_next;
                    state_next   = ST_IDLE;
                end
            end

            ST_MISC: begin
                if (out_free) begin
                    // Restart clears the table and the flag; a no-op only
                    // reports the flag.
                    tctrl.clr_all  = restart_reg;
                    sat_flag_next  = sat_flag_reg && !restart_reg;
                    out_valid_next = 1'b1;
                    out_len_next   = '0;
                    out_cnt_next   = '0;
                    out_sat_next   = sat_flag_next;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;
    assign length       = out_len_reg;
    assign path_count   = out_cnt_reg;
    assign saturated    = out_sat_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // An accepted beat always leaves the idle state, so the table is never
    // read for two items at once.
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        item_acc |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start work");

    // A committed restart reports and keeps a clear saturation flag.
    a_restart_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MISC && restart_reg && out_free)
        |=> (result_valid && !saturated && !sat_flag_reg))
        else $error("restart left the saturation flag set");

    // The table is written only when an edge result is committed.
    a_write_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        tctrl.wr_en |-> (state_reg == ST_EDGE && out_free && edge_ok_reg))
        else $error("vertex table written outside an edge commit");

    // A new result appears only after a work state.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) != ST_IDLE))
        else $error("result raised without work");

endmodule
